// ===== rtl/aes_sbox_forward_core_macros.svh =====
// Assertion macros shared by the core. Define NO_ASSERTIONS to compile them out.
`ifndef AES_SBOX_FORWARD_CORE_MACROS_SVH
`define AES_SBOX_FORWARD_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of clk outside reset.
`define SBF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("aes_sbox_forward_core: assertion failed");

// Checked on every rising edge of clk, reset included.
`define SBF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("aes_sbox_forward_core: assertion failed");

`else

`define SBF_ASSERT(label, prop)
`define SBF_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== rtl/aes_sbf_pkg.sv =====
package aes_sbf_pkg;

  typedef logic [7:0] byte_t;

  // Field polynomial x^8+x^4+x^3+x+1.
  localparam logic [8:0]  GF_POLY     = 9'h11B;
  // Row i of the affine matrix sits in bits 8*i+7 down to 8*i.
  localparam logic [63:0] AFFINE_ROWS = 64'hF87C3E1F8FC7E3F1;
  localparam byte_t       AFFINE_ADD  = 8'h63;
  // Cycles from an accepted start to its done strobe.
  localparam int          LATENCY     = 4;

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ sh;
      end
      sh = sh[7] ? ((sh << 1) ^ GF_POLY[7:0]) : (sh << 1);
    end
    return acc;
  endfunction

  // Squaring is linear over GF(2): spread the bits, then reduce.
  function automatic byte_t gf_sq(input byte_t a);
    logic [14:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      p[2*i] = a[i];
    end
    for (int k = 14; k >= 8; k--) begin
      if (p[k]) begin
        p = p ^ (15'(GF_POLY) << (k - 8));
      end
    end
    return p[7:0];
  endfunction

  // a raised to 2^n, n at most 7; a chain of linear maps.
  function automatic byte_t gf_pow2n(input byte_t a, input int n);
    byte_t r;
    r = a;
    for (int i = 0; i < 7; i++) begin
      if (i < n) begin
        r = gf_sq(r);
      end
    end
    return r;
  endfunction

  function automatic byte_t affine(input byte_t x);
    byte_t res;
    byte_t row;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      row    = AFFINE_ROWS[8*i +: 8];
      res[i] = ^(row & x);
    end
    return res ^ AFFINE_ADD;
  endfunction

endpackage

// ===== rtl/aes_sbox_forward_core.sv =====
// Forward AES S-box, fully pipelined. A byte is taken on every clock edge at
// which start is high; busy is tied low, so a new byte may follow every cycle.
// Once through the pipe, done is high for exactly one cycle with sub_byte (the
// S-box value) and inverse_byte (the GF(2^8) inverse, zero for zero). The
// depth is set by the inversion, three stages of field multipliers, plus one
// stage for the affine transform. The receiver cannot stall the results, and
// none is dropped or repeated. Reset clears only the valid bits.
`include "aes_sbox_forward_core_macros.svh"

module aes_sbox_forward_core
  import aes_sbf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  byte_t in_byte,
  output logic  done,
  output byte_t sub_byte,
  output byte_t inverse_byte
);

  logic  inv_valid;
  byte_t inv_data;

  assign busy = 1'b0;

  aes_sbf_inv u_inv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_data   (in_byte),
    .out_valid (inv_valid),
    .out_inv   (inv_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= inv_valid;
    end
  end

  always_ff @(posedge clk) begin
    sub_byte     <= affine(inv_data);
    inverse_byte <= inv_data;
  end

  `SBF_ASSERT(a_done_follows_start, done |-> $past(start && !busy, LATENCY))
  `SBF_ASSERT(a_zero_maps_to_zero, done |-> ((|$past(in_byte, LATENCY)) == (|inverse_byte)))
  `SBF_ASSERT(a_zero_sub_value, (done && inverse_byte == 8'h00) |-> (sub_byte == AFFINE_ADD))
  `SBF_ASSERT_ALWAYS(a_no_done_in_reset, $past(rst) |-> !done)

endmodule

// ===== rtl/aes_sbf_inv.sv =====
module aes_sbf_inv
  import aes_sbf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  byte_t in_data,
  output logic  out_valid,
  output byte_t out_inv
);

  // The inverse is x^254 = ((x^2 * x^4) * (x^8 * x^16)) * ((x^32 * x^64) * x^128).
  // Squarings are free linear maps, so each stage holds one level of multipliers.
  logic  s1_valid;
  byte_t s1_p6;
  byte_t s1_p24;
  byte_t s1_p96;
  byte_t s1_p128;
  logic  s2_valid;
  byte_t s2_p30;
  byte_t s2_p224;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_p6   <= gf_mul(gf_pow2n(in_data, 1), gf_pow2n(in_data, 2));
    s1_p24  <= gf_mul(gf_pow2n(in_data, 3), gf_pow2n(in_data, 4));
    s1_p96  <= gf_mul(gf_pow2n(in_data, 5), gf_pow2n(in_data, 6));
    s1_p128 <= gf_pow2n(in_data, 7);
    s2_p30  <= gf_mul(s1_p6, s1_p24);
    s2_p224 <= gf_mul(s1_p96, s1_p128);
    out_inv <= gf_mul(s2_p30, s2_p224);
  end

endmodule

// ===== tb/sv/tb_aes_sbox_forward_core.sv =====
`timescale 1ns / 100ps

module tb_aes_sbox_forward_core
  import aes_sbf_pkg::*;
();

  localparam logic [8:0]  FIELD_POLY   = 9'h11B;
  localparam logic [63:0] MATRIX_ROWS  = 64'hF87C3E1F8FC7E3F1;
  localparam byte_t       AFFINE_CONST = 8'h63;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          NUM_VECTORS  = 20;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          MAX_REPORTS  = 10;

  typedef struct packed {
    byte_t sub;
    byte_t inv;
  } sbox_result_t;

  typedef struct packed {
    byte_t din;
    logic  known;
    byte_t sub;
    byte_t inv;
  } vector_t;

  // Only the first rows carry hand-typed answers; the rest use the predictor.
  localparam vector_t VECTORS [NUM_VECTORS] = '{
    '{8'h00, 1'b1, 8'h63, 8'h00},
    '{8'h01, 1'b1, 8'h7C, 8'h01},
    '{8'hFF, 1'b1, 8'h16, 8'h1C},
    '{8'h53, 1'b1, 8'hED, 8'hCA},
    '{8'h02, 1'b0, 8'h00, 8'h00},
    '{8'h04, 1'b0, 8'h00, 8'h00},
    '{8'h08, 1'b0, 8'h00, 8'h00},
    '{8'h10, 1'b0, 8'h00, 8'h00},
    '{8'h20, 1'b0, 8'h00, 8'h00},
    '{8'h40, 1'b0, 8'h00, 8'h00},
    '{8'h80, 1'b0, 8'h00, 8'h00},
    '{8'h7F, 1'b0, 8'h00, 8'h00},
    '{8'hFE, 1'b0, 8'h00, 8'h00},
    '{8'hAA, 1'b0, 8'h00, 8'h00},
    '{8'h55, 1'b0, 8'h00, 8'h00},
    '{8'h0F, 1'b0, 8'h00, 8'h00},
    '{8'hF0, 1'b0, 8'h00, 8'h00},
    '{8'h8D, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 8'h00, 8'h00}
  };

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  byte_t in_byte;
  logic  done;
  byte_t sub_byte;
  byte_t inverse_byte;

  // Hand-typed answer travelling alongside the byte being offered.
  logic  row_known;
  byte_t row_sub;
  byte_t row_inv;

  sbox_result_t pending_q[$];
  int           cycles;
  int           errors;
  int           accepted;
  int           checked;
  bit           seen [256];

  aes_sbox_forward_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .in_byte      (in_byte),
    .done         (done),
    .sub_byte     (sub_byte),
    .inverse_byte (inverse_byte)
  );

  function automatic byte_t gf_times(input byte_t a, input byte_t b);
    logic [8:0] sh;
    byte_t      acc;
    acc = '0;
    sh  = {1'b0, a};
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc ^= sh[7:0];
      end
      sh = sh << 1;
      if (sh[8]) begin
        sh ^= FIELD_POLY;
      end
    end
    return acc;
  endfunction

  // x^254 is the field inverse for nonzero x and zero for zero.
  function automatic byte_t gf_reciprocal(input byte_t x);
    byte_t acc;
    byte_t pw;
    int    e;
    acc = 8'h01;
    pw  = x;
    e   = 254;
    while (e != 0) begin
      if (e[0]) begin
        acc = gf_times(acc, pw);
      end
      pw = gf_times(pw, pw);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic sbox_result_t sbox_of(input byte_t x);
    sbox_result_t r;
    byte_t        lin;
    r.inv = gf_reciprocal(x);
    for (int i = 0; i < 8; i++) begin
      lin[i] = ^(MATRIX_ROWS[8*i +: 8] & r.inv);
    end
    r.sub = lin ^ AFFINE_CONST;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input byte_t exp_v, input byte_t act_v);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("mismatch on %s at cycle %0d: expected %02h, got %02h",
               what, cycles, exp_v, act_v);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("aes_sbox_forward_core test failed");
      $finish;
    end
  end

  // Record each accepted transaction and check each strobed result.
  always @(posedge clk) begin
    sbox_result_t want;
    if (!rst) begin
      if (start && !busy) begin
        if (row_known) begin
          want.sub = row_sub;
          want.inv = row_inv;
        end else begin
          want = sbox_of(in_byte);
        end
        pending_q.push_back(want);
        seen[in_byte] = 1'b1;
        accepted++;
      end
      if (done) begin
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("unexpected result at cycle %0d: sub_byte %02h inverse_byte %02h",
                     cycles, sub_byte, inverse_byte);
          end
        end else begin
          want = pending_q.pop_front();
          checked++;
          if (sub_byte !== want.sub) begin
            note_mismatch("sub_byte", want.sub, sub_byte);
          end
          if (inverse_byte !== want.inv) begin
            note_mismatch("inverse_byte", want.inv, inverse_byte);
          end
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge that accepts the transaction.
  task automatic offer_byte(input byte_t v, input logic k, input byte_t s, input byte_t i,
                            input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_byte   <= v;
    row_known <= k;
    row_sub   <= s;
    row_inv   <= i;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  initial begin
    int    idle_pct;
    int    distinct;
    int    wait_cycles;
    byte_t v;
    rst       = 1'b1;
    start     = 1'b0;
    in_byte   = '0;
    row_known = 1'b0;
    row_sub   = '0;
    row_inv   = '0;
    cycles    = 0;
    errors    = 0;
    accepted  = 0;
    checked   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (VECTORS[n]) begin
      offer_byte(VECTORS[n].din, VECTORS[n].known, VECTORS[n].sub, VECTORS[n].inv, 9);
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 9 : (phase == 1) ? 86 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        case ($urandom_range(19))
          0:       v = 8'h00;
          1:       v = 8'hFF;
          2:       v = 8'h01 << $urandom_range(7);
          default: v = byte_t'($urandom_range(255));
        endcase
        offer_byte(v, 1'b0, 8'h00, 8'h00, idle_pct);
      end
    end
    start     <= 1'b0;
    row_known <= 1'b0;

    while (pending_q.size() != 0) begin
      @(negedge clk);
    end
    wait_cycles = LATENCY + 8;
    repeat (wait_cycles) @(posedge clk);

    distinct = 0;
    foreach (seen[n]) begin
      distinct += seen[n];
    end
    $display("Sent %0d bytes (%0d distinct values) and checked %0d substitutions,",
             accepted, distinct, checked);
    $display("with sparse, heavy and no gaps between transactions; %0d errors.", errors);
    if (errors == 0) begin
      $display("aes_sbox_forward_core test passed");
    end else begin
      $display("aes_sbox_forward_core test failed");
    end
    $finish;
  end

endmodule
